[design/gkpsf_pkg.sv]
// ----------------------------------------------------------------------------
// gkpsf_pkg
// Shared types, constants and grid helper functions for the grid key
// permute / shard filter block.
// ----------------------------------------------------------------------------
`default_nettype none

package gkpsf_pkg;

    localparam int KEY_W    = 64;
    localparam int WEIGHT_W = 64;
    localparam int SHARD_W  = 32;
    localparam int CNT_W    = 64;
    localparam int PREFIX_W = 32;
    localparam int HALF_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = KEY_W + WEIGHT_W;
    localparam int M_TDATA_W = KEY_W + WEIGHT_W + 6 * CNT_W;
    localparam int M_TUSER_W = 3;

    // splitmix64 finalizer constants
    localparam logic [63:0] C_MIX_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] C_MIX_B = 64'h94d049bb133111eb;
    localparam int C_SHIFT_0 = 30;
    localparam int C_SHIFT_1 = 27;
    localparam int C_SHIFT_2 = 31;
    localparam logic [3:0] C_NIBBLE_MASK = 4'hF;
    localparam logic [3:0] C_SEL_COLS    = 4'd4;

    // sequencing
    localparam int CNT_SEQ_W  = 6;
    localparam int C_MUL_LAST = 3;
    localparam int C_DIV_LAST = KEY_W - 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARD_CNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OWNER     = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_WT    = 2'd1;
    localparam logic [1:0] ST_BAD_MASK   = 2'd2;
    localparam logic [1:0] ST_BAD_OWNER  = 2'd3;

    // multiplier partial product selects
    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_LH = 2'd1;
    localparam logic [1:0] MUL_HL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_MIX,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       mul_go;
        logic [1:0] mul_sel;
        logic       acc_add;
        logic [1:0] add_sel;
        logic       mix;
        logic       round;
        logic       div_step;
        logic       commit;
    } t_dp_cmd;

    typedef struct packed {
        logic ok;
        logic filter_on;
    } t_dp_stat;

    function automatic logic [3:0] f_popcount8(input logic [7:0] m);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, m[i]};
        end
        return n;
    endfunction

    function automatic logic [63:0] f_transpose(input logic [63:0] g);
        logic [63:0] r;
        r = '0;
        for (int row = 0; row < 8; row++) begin
            for (int col = 0; col < 8; col++) begin
                r[8 * (7 - col) + row] = g[8 * (7 - row) + col];
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] f_reorder(input logic [63:0] g, input logic [7:0] mask);
        logic [2:0] seq [0:7];
        logic [3:0] n;
        logic [63:0] r;
        n = '0;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            seq[i] = '0;
        end
        for (int c = 0; c < 8; c++) begin
            if (mask[c]) begin
                seq[n[2:0]] = 3'(c);
                n = n + 4'd1;
            end
        end
        for (int c = 0; c < 8; c++) begin
            if (!mask[c]) begin
                seq[n[2:0]] = 3'(c);
                n = n + 4'd1;
            end
        end
        for (int row = 0; row < 8; row++) begin
            for (int o = 0; o < 8; o++) begin
                r[8 * row + o] = g[8 * row + int'(seq[o])];
            end
        end
        return r;
    endfunction

    // low nibble of each row, row 0 in the top nibble
    function automatic logic [31:0] f_prefix(input logic [63:0] g);
        logic [31:0] p;
        p = '0;
        for (int k = 0; k < 8; k++) begin
            p[4 * k +: 4] = g[8 * k +: 4] & C_NIBBLE_MASK;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[design/gkpsf_ctrl.sv]
// ----------------------------------------------------------------------------
// gkpsf_ctrl
// Sequencer: input/output handshakes, multiply steps, mix rounds and the
// bit-serial remainder loop.
// ----------------------------------------------------------------------------
`default_nettype none

module gkpsf_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    input  gkpsf_pkg::t_dp_stat  i_stat,
    output gkpsf_pkg::t_dp_cmd   o_cmd
);
    import gkpsf_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_SEQ_W-1:0] r_cnt, n_cnt;
    logic                 r_round, n_round;
    logic                 r_m_valid, n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_round   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_round   <= n_round;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_round   = r_round;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.ok && i_stat.filter_on) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                    n_round = 1'b0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                // product of step k is folded into the accumulator at step k+1
                o_cmd.mul_go  = (r_cnt != CNT_SEQ_W'(C_MUL_LAST));
                o_cmd.mul_sel = r_cnt[1:0];
                o_cmd.acc_add = (r_cnt != '0);
                o_cmd.add_sel = r_cnt[1:0] - 2'd1;
                o_cmd.round   = r_round;
                if (r_cnt == CNT_SEQ_W'(C_MUL_LAST)) begin
                    n_state = S_MIX;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MIX: begin
                o_cmd.mix   = 1'b1;
                o_cmd.round = r_round;
                n_cnt       = '0;
                if (!r_round) begin
                    n_round = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_SEQ_W'(C_DIV_LAST)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_m_valid    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

`default_nettype wire

[design/gkpsf_dp.sv]
// ----------------------------------------------------------------------------
// gkpsf_dp
// Datapath: configuration registers, grid permute, 32x32 multiplier for the
// finalizer, restoring remainder unit, running counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gkpsf_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [gkpsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [gkpsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire  [gkpsf_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  gkpsf_pkg::t_dp_cmd                   i_cmd,
    output gkpsf_pkg::t_dp_stat                  o_stat,
    output logic [gkpsf_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic [gkpsf_pkg::M_TUSER_W-1:0]      o_m_tuser
);
    import gkpsf_pkg::*;

    // configuration
    logic               r_transpose;
    logic [7:0]         r_sel_cols;
    logic               r_filter_en;
    logic [SHARD_W-1:0] r_shard_cnt;
    logic [SHARD_W-1:0] r_owner;

    // per-record working registers
    logic [KEY_W-1:0]    r_key;
    logic [WEIGHT_W-1:0] r_weight;
    logic [1:0]          r_status;
    logic [63:0]         r_hv;
    logic [63:0]         r_prod;
    logic [63:0]         r_acc;
    logic [SHARD_W-1:0]  r_rem;

    // running totals
    logic [CNT_W-1:0]    r_seen_cnt;
    logic [CNT_W-1:0]    r_kept_cnt;
    logic [2*CNT_W-1:0]  r_seen_wt;
    logic [2*CNT_W-1:0]  r_kept_wt;

    // result registers
    logic [KEY_W-1:0]    r_o_key;
    logic [WEIGHT_W-1:0] r_o_weight;
    logic                r_o_kept;
    logic [1:0]          r_o_status;

    logic [KEY_W-1:0]    in_key;
    logic [WEIGHT_W-1:0] in_weight;
    logic [KEY_W-1:0]    perm_key;
    logic [PREFIX_W-1:0] prefix;
    logic [1:0]          n_status;
    logic [63:0]         mul_k;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [63:0]         mixed;
    logic [SHARD_W:0]    rem_shift;
    logic [SHARD_W:0]    rem_diff;
    logic                keep;

    assign in_key    = i_s_tdata[KEY_W-1:0];
    assign in_weight = i_s_tdata[KEY_W +: WEIGHT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose <= 1'b0;
            r_sel_cols  <= 8'h0F;
            r_filter_en <= 1'b0;
            r_shard_cnt <= 32'd1;
            r_owner     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRANSPOSE: r_transpose <= i_cfg_data[0];
                CFG_SEL_COLS:  r_sel_cols  <= i_cfg_data[7:0];
                CFG_FILTER_EN: r_filter_en <= i_cfg_data[0];
                CFG_SHARD_CNT: r_shard_cnt <= i_cfg_data;
                CFG_OWNER:     r_owner     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        perm_key = f_reorder(r_transpose ? f_transpose(in_key) : in_key, r_sel_cols);
        prefix   = f_prefix(perm_key);
        if (f_popcount8(r_sel_cols) != C_SEL_COLS) begin
            n_status = ST_BAD_MASK;
        end else if (r_owner >= r_shard_cnt) begin
            n_status = ST_BAD_OWNER;
        end else if (in_weight == '0) begin
            n_status = ST_ZERO_WT;
        end else begin
            n_status = ST_OK;
        end
    end

    // operand selection for the 64x64 (low half) product in three pieces
    always_comb begin
        mul_k = i_cmd.round ? C_MIX_B : C_MIX_A;
        case (i_cmd.mul_sel)
            MUL_LL: begin
                mul_a = r_hv[HALF_W-1:0];
                mul_b = mul_k[HALF_W-1:0];
            end
            MUL_LH: begin
                mul_a = r_hv[HALF_W-1:0];
                mul_b = mul_k[63:HALF_W];
            end
            MUL_HL: begin
                mul_a = r_hv[63:HALF_W];
                mul_b = mul_k[HALF_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mixed = i_cmd.round ? (r_acc ^ (r_acc >> C_SHIFT_2)) : (r_acc ^ (r_acc >> C_SHIFT_1));
    end

    assign rem_shift = {r_rem, r_hv[63]};
    assign rem_diff  = rem_shift - {1'b0, r_shard_cnt};
    assign keep      = (r_status == ST_OK) && (!r_filter_en || (r_rem == r_owner));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= (n_status == ST_OK) ? perm_key : '0;
            r_weight <= in_weight;
            r_status <= n_status;
            r_hv     <= {32'd0, prefix} ^ ({32'd0, prefix} >> C_SHIFT_0);
        end else if (i_cmd.mix) begin
            r_hv  <= mixed;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_hv <= {r_hv[62:0], 1'b0};
            if (!rem_diff[SHARD_W]) begin
                r_rem <= rem_diff[SHARD_W-1:0];
            end else begin
                r_rem <= rem_shift[SHARD_W-1:0];
            end
        end
        if (i_cmd.mul_go) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_add) begin
            if (i_cmd.add_sel == MUL_LL) begin
                r_acc <= r_prod;
            end else begin
                r_acc <= r_acc + {r_prod[HALF_W-1:0], 32'd0};
            end
        end
        if (i_cmd.commit) begin
            r_o_key    <= r_key;
            r_o_weight <= r_weight;
            r_o_kept   <= keep;
            r_o_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_cnt <= '0;
            r_kept_cnt <= '0;
            r_seen_wt  <= '0;
            r_kept_wt  <= '0;
        end else if (i_cmd.commit && (r_status == ST_OK)) begin
            r_seen_cnt <= r_seen_cnt + 1'b1;
            r_seen_wt  <= r_seen_wt + {64'd0, r_weight};
            if (keep) begin
                r_kept_cnt <= r_kept_cnt + 1'b1;
                r_kept_wt  <= r_kept_wt + {64'd0, r_weight};
            end
        end
    end

    assign o_stat.ok        = (r_status == ST_OK);
    assign o_stat.filter_on = r_filter_en;

    assign o_m_tdata = {r_kept_wt, r_seen_wt, r_kept_cnt, r_seen_cnt, r_o_weight, r_o_key};
    assign o_m_tuser = {r_o_status, r_o_kept};

endmodule

`default_nettype wire

[design/grid_key_permute_shard_filter.sv]
// Sequence: accept, check, then result for error records or with filtering off;
//   with filtering on, two 4-step 32x32 multiply passes, each followed by a mix
//   step, and the 64-step restoring remainder loop come between check and result.
// One record at a time: the next is accepted only after the last result is committed.
// Reset: synchronous active low; clears counters, handshakes and the
//   configuration to its defaults (mask 0x0F, shard count 1, rest 0).
// ----------------------------------------------------------------------------
// grid_key_permute_shard_filter
// 8x8 grid key permute with splitmix64 shard filter and running totals.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_key_permute_shard_filter (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write channel
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [gkpsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [gkpsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: grid_key[63:0], record_weight[127:64]
    input  wire  [gkpsf_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // output stream
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    // tdata: out_key, out_weight, records_seen, records_kept, seen_weight_low,
    //        seen_weight_high, kept_weight_low, kept_weight_high (64 bits each)
    output logic [gkpsf_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // tuser: kept[0], status[2:1]
    output logic [gkpsf_pkg::M_TUSER_W-1:0]      o_m_tuser
);
    import gkpsf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    gkpsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gkpsf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

[test/tb_grid_key_permute_shard_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_key_permute_shard_filter
// Self-checking bench for the grid key permute / shard filter block. A
// tracker class mirrors the configuration, the running counts and the 128-bit
// weight sums. For every input transaction it predicts the result, and it
// compares each output transaction field by field, in order. A directed
// opener covers field extremes, error priority and ignored register indexes.
// Random phases follow, each with fresh register settings. Most have random
// gaps on both streams; one has a long output hold-off, another a mid-phase drain.
// ----------------------------------------------------------------------------

module tb_grid_key_permute_shard_filter;
    import gkpsf_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_TAIL    = 90;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_RECORDS = 100;
    localparam longint LIMIT_NS  = 3_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [31:0] SHARD_MAX  = 32'hFFFF_FFFF;
    localparam logic [63:0] WEIGHT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [63:0]  key;
        logic [63:0]  weight;
        logic         kept;
        logic [1:0]   status;
        logic [63:0]  seen_cnt;
        logic [63:0]  kept_cnt;
        logic [127:0] seen_sum;
        logic [127:0] kept_sum;
    } t_shard_result;

    class t_shard_filter_tracker;
        localparam int PRINT_CAP = 60;

        logic         transpose_on;
        logic [7:0]   col_mask;
        logic         filter_on;
        logic [31:0]  shards;
        logic [31:0]  owner;
        logic [63:0]  seen_cnt;
        logic [63:0]  kept_cnt;
        logic [127:0] seen_sum;
        logic [127:0] kept_sum;
        t_shard_result expected_results[$];
        int errors;

        function new();
            transpose_on = 1'b0;
            col_mask     = 8'h0F;
            filter_on    = 1'b0;
            shards       = 32'd1;
            owner        = 32'd0;
            seen_cnt     = '0;
            kept_cnt     = '0;
            seen_sum     = '0;
            kept_sum     = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TRANSPOSE: transpose_on = data[0];
                CFG_SEL_COLS:  col_mask     = data[7:0];
                CFG_FILTER_EN: filter_on    = data[0];
                CFG_SHARD_CNT: shards       = data;
                CFG_OWNER:     owner        = data;
                default: ;
            endcase
        endfunction

        // row r lives in byte 7-r, column c is bit c of the byte
        function logic [63:0] flip_grid(logic [63:0] g);
            logic [63:0] r;
            r = '0;
            for (int row = 0; row < 8; row++) begin
                for (int col = 0; col < 8; col++) begin
                    r[8 * (7 - col) + row] = g[8 * (7 - row) + col];
                end
            end
            return r;
        endfunction

        // selected columns first, then the rest, each ascending
        function logic [63:0] reorder_columns(logic [63:0] g, logic [7:0] m);
            int order [8];
            int n;
            logic [63:0] r;
            n = 0;
            r = '0;
            for (int c = 0; c < 8; c++) begin
                if (m[c]) begin
                    order[n] = c;
                    n++;
                end
            end
            for (int c = 0; c < 8; c++) begin
                if (!m[c]) begin
                    order[n] = c;
                    n++;
                end
            end
            for (int b = 0; b < 8; b++) begin
                for (int o = 0; o < 8; o++) begin
                    r[8 * b + o] = g[8 * b + order[o]];
                end
            end
            return r;
        endfunction

        function logic [31:0] row_nibbles(logic [63:0] g);
            logic [31:0] p;
            p = '0;
            for (int row = 0; row < 8; row++) begin
                p = {p[27:0], g[8 * (7 - row) +: 4]};
            end
            return p;
        endfunction

        function logic [63:0] mix64(logic [63:0] v);
            v = v ^ (v >> C_SHIFT_0);
            v = v * C_MIX_A;
            v = v ^ (v >> C_SHIFT_1);
            v = v * C_MIX_B;
            return v ^ (v >> C_SHIFT_2);
        endfunction

        function void note_record(logic [63:0] key, logic [63:0] w);
            t_shard_result e;
            logic [63:0] g;
            e.key    = '0;
            e.weight = w;
            e.kept   = 1'b0;
            if ($countones(col_mask) != int'(C_SEL_COLS)) begin
                e.status = ST_BAD_MASK;
            end else if (owner >= shards) begin
                e.status = ST_BAD_OWNER;
            end else if (w == '0) begin
                e.status = ST_ZERO_WT;
            end else begin
                e.status = ST_OK;
            end
            if (e.status == ST_OK) begin
                g     = transpose_on ? flip_grid(key) : key;
                e.key = reorder_columns(g, col_mask);
                if (filter_on) begin
                    e.kept = (mix64({32'b0, row_nibbles(e.key)}) % {32'b0, shards})
                             == {32'b0, owner};
                end else begin
                    e.kept = 1'b1;
                end
                seen_cnt = seen_cnt + 64'd1;
                seen_sum = seen_sum + {64'b0, w};
                if (e.kept) begin
                    kept_cnt = kept_cnt + 64'd1;
                    kept_sum = kept_sum + {64'b0, w};
                end
            end
            e.seen_cnt = seen_cnt;
            e.kept_cnt = kept_cnt;
            e.seen_sum = seen_sum;
            e.kept_sum = kept_sum;
            expected_results.push_back(e);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
            end
        endtask

        task check_result(logic [M_TDATA_W-1:0] d, logic [M_TUSER_W-1:0] u);
            t_shard_result e;
            logic [63:0] got [10];
            logic [63:0] want [10];
            string tag [10];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transaction, key", d[63:0], '0);
                return;
            end
            e = expected_results.pop_front();
            tag = '{"out_key", "out_weight", "kept", "status", "records_seen",
                    "records_kept", "seen_weight_low", "seen_weight_high",
                    "kept_weight_low", "kept_weight_high"};
            got[0] = d[63:0];     want[0] = e.key;
            got[1] = d[127:64];   want[1] = e.weight;
            got[2] = {63'b0, u[0]};   want[2] = {63'b0, e.kept};
            got[3] = {62'b0, u[2:1]}; want[3] = {62'b0, e.status};
            got[4] = d[191:128];  want[4] = e.seen_cnt;
            got[5] = d[255:192];  want[5] = e.kept_cnt;
            got[6] = d[319:256];  want[6] = e.seen_sum[63:0];
            got[7] = d[383:320];  want[7] = e.seen_sum[127:64];
            got[8] = d[447:384];  want[8] = e.kept_sum[63:0];
            got[9] = d[511:448];  want[9] = e.kept_sum[127:64];
            for (int i = 0; i < 10; i++) begin
                if (got[i] !== want[i]) begin
                    report_mismatch(tag[i], got[i], want[i]);
                end
            end
        endtask

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic [S_TDATA_W-1:0]   s_data = '0;
    logic                   m_ready = 1'b0;
    wire                    cfg_ready;
    wire                    s_ready;
    wire                    m_valid;
    wire  [M_TDATA_W-1:0]   m_data;
    wire  [M_TUSER_W-1:0]   m_user;

    bit hold_req = 1'b0;
    bit idle_on = 1'b1;
    t_shard_filter_tracker tracker = new();

    grid_key_permute_shard_filter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .o_m_tuser   (m_user)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly short idles, now and then a long one
    function automatic int pick_idle();
        if ($urandom_range(99, 0) < 85) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(50, 15);
    endfunction

    function automatic int sender_gap();
        if (!idle_on || $urandom_range(99, 0) < 70) begin
            return 0;
        end
        return pick_idle();
    endfunction

    function automatic logic [63:0] random_key();
        int r;
        r = $urandom_range(99, 0);
        if (r < 75) return {$urandom(), $urandom()};
        if (r < 82) return 64'd1 << $urandom_range(63, 0);
        if (r < 87) return '1;
        if (r < 90) return '0;
        if (r < 95) return {8{8'($urandom())}};
        return 64'($urandom_range(255, 0)) << (8 * $urandom_range(7, 0));
    endfunction

    function automatic logic [63:0] random_weight();
        int r;
        r = $urandom_range(99, 0);
        if (r < 3)  return '0;
        if (r < 8)  return WEIGHT_MAX;
        if (r < 18) return 64'($urandom_range(1000, 1));
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [7:0] random_mask(bit four_cols);
        logic [7:0] m;
        do begin
            m = 8'($urandom_range(255, 0));
        end while (($countones(m) == int'(C_SEL_COLS)) != four_cols);
        return m;
    endfunction

    function automatic logic [31:0] random_shards();
        int r;
        r = $urandom_range(99, 0);
        if (r < 45) return $urandom_range(4, 1);
        if (r < 70) return $urandom_range(64, 5);
        if (r < 85) return $urandom();
        if (r < 95) return SHARD_MAX;
        return '0;
    endfunction

    // output side: random stalls plus one requested long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_on && $urandom_range(99, 0) < 20) begin
                stall_left = pick_idle();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            tracker.check_result(m_data, m_user);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_record(logic [63:0] key, logic [63:0] w);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {w, key};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        tracker.note_record(key, w);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // unused upper data bits carry noise; the block must mask them off
    task automatic configure(bit tr, logic [7:0] m, bit flt, logic [31:0] sc, logic [31:0] ow);
        logic [31:0] junk;
        junk = $urandom();
        drain_results();
        write_reg(CFG_TRANSPOSE, {junk[31:1], tr});
        write_reg(CFG_SEL_COLS, {junk[31:8], m});
        write_reg(CFG_FILTER_EN, {junk[30:0], flt});
        write_reg(CFG_SHARD_CNT, sc);
        write_reg(CFG_OWNER, ow);
        if ($urandom_range(2, 0) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), $urandom());
        end
    endtask

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        bit mask_ok;
        bit owner_ok;
        logic [31:0] sc;
        logic [31:0] ow;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: identity reorder, no filter
        send_record(64'h0, 64'h1);
        send_record('1, WEIGHT_MAX);
        send_record(64'h0123_4567_89AB_CDEF, WEIGHT_MAX);  // second all-ones weight; the high sum word is already one
        send_record(64'h8000_0000_0000_0001, 64'h0);

        configure(1'b1, 8'hF0, 1'b1, 32'd3, 32'd2);
        send_record(64'h0102_0408_1020_4080, 64'h8000_0000_0000_0000);
        send_record(64'hFF00_0000_0000_00FF, 64'h8000_0000_0000_0000);
        send_record(64'h8040_2010_0804_0201, 64'd7);
        send_record({$urandom(), $urandom()}, {$urandom(), $urandom()});

        configure(1'b0, 8'hA5, 1'b1, SHARD_MAX, SHARD_MAX - 32'd1);
        send_record({$urandom(), $urandom()}, WEIGHT_MAX);
        send_record('1, 64'd3);

        configure(1'b1, 8'h3C, 1'b1, 32'd1, 32'd0);
        send_record(64'hF0F0_F0F0_0F0F_0F0F, 64'd9);
        send_record({$urandom(), $urandom()}, {$urandom(), $urandom()});

        // mask check wins over weight and owner checks
        configure(1'b0, 8'hFF, 1'b0, 32'd1, 32'd0);
        send_record('1, 64'h0);
        send_record('1, 64'd5);
        configure(1'b0, 8'h00, 1'b1, 32'd0, 32'd0);
        send_record('1, 64'h0);

        // owner range is tested with filtering off, also for zero shards
        configure(1'b1, 8'h3C, 1'b0, 32'd0, 32'd0);
        send_record(64'h1234_5678_9ABC_DEF0, 64'h0);
        send_record(64'h1234_5678_9ABC_DEF0, 64'd11);
        configure(1'b0, 8'hC3, 1'b0, 32'd5, 32'd5);
        send_record({$urandom(), $urandom()}, 64'd2);

        // writes above the last register index change nothing
        configure(1'b0, 8'h0F, 1'b0, 32'd1, 32'd0);
        write_reg(CFG_SPARE_HI, '1);
        write_reg(CFG_SPARE_LO, '0);
        send_record({$urandom(), $urandom()}, 64'd4);
        send_record({$urandom(), $urandom()}, WEIGHT_MAX);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            idle_on  = (p % 4 != 1);
            mask_ok  = $urandom_range(99, 0) < 85;
            owner_ok = $urandom_range(99, 0) < 85;
            sc = random_shards();
            if (owner_ok && sc != '0) begin
                ow = $urandom_range(sc - 32'd1, 0);
            end else if (sc == SHARD_MAX) begin
                ow = SHARD_MAX;
            end else begin
                ow = $urandom_range(SHARD_MAX, sc);
            end
            configure(1'($urandom()), random_mask(mask_ok), 1'($urandom()), sc, ow);
            if (p == 2) begin
                hold_req = 1'b1;  // sender keeps offering while the output is held
            end
            for (int n = 0; n < PHASE_RECORDS; n++) begin
                send_record(random_key(), random_weight());
                if (p == 6 && n == PHASE_RECORDS / 2) begin
                    drain_results();
                end
            end
        end

        drain_results();
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/gkpsf_pkg.sv
design/gkpsf_ctrl.sv
design/gkpsf_dp.sv
design/grid_key_permute_shard_filter.sv
test/tb_grid_key_permute_shard_filter.sv
